@@ rtl/seven_segment_mux_scanner_macros.svh @@
// Assertion macros shared by the display scanner RTL.
`ifndef SEVEN_SEGMENT_MUX_SCANNER_MACROS_SVH
`define SEVEN_SEGMENT_MUX_SCANNER_MACROS_SVH

`ifndef ASSERT_OFF
// Clocked check, idle while reset is asserted.
`define SSMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define SSMS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SSMS_ASSERT(lbl, prop, msg)
`define SSMS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/ssms_pkg.sv @@
// Shared types and constants of the seven-segment scanner.
`timescale 1ns / 1ps
`default_nettype none
package ssms_pkg;

	localparam int REQ_W = 2;
	localparam int SYM_W = 8;
	localparam int POS_W = 2;
	localparam int SEG_W = 8;
	localparam int DIG_W = 4;
	localparam int TICK_W = 8;
	localparam int APB_DW = 32;
	localparam int PADDR_W = 3;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam int NUM_DIGITS_DEF = 4;

	localparam logic [TICK_W-1:0] SCAN_PERIOD_RST = TICK_W'(5);
	localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
	localparam logic [SYM_W-1:0] CH_NUL = 8'h00;
	localparam logic [SYM_W-1:0] CH_MINUS = 8'h2A;
	localparam logic [SYM_W-1:0] CH_UNDERSCORE = 8'h23;
	localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
	localparam logic [SEG_W-1:0] SEG_UNDERSCORE = 8'h08;
	localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

	// Register index of the scan period register.
	localparam logic [REG_IDX_W-1:0] REG_SCAN_PERIOD = REG_IDX_W'(0);

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK  = 2'd0,
		REQ_PUSH  = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_CLEAR = 2'd3
	} req_type_t;

	typedef struct packed {
		logic [SEG_W-1:0] seg;
		logic [DIG_W-1:0] dig;
		logic             strobe;
	} disp_item_t;

endpackage
`default_nettype wire

@@ rtl/ssms_if.sv @@
// Item channels of the scanner: command in, display result out.
`timescale 1ns / 1ps
`default_nettype none
interface ssms_cmd_if import ssms_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [SYM_W-1:0] symbol;
	logic [POS_W-1:0] position;

	modport source (output valid, req_type, symbol, position, input ready);
	modport sink (input valid, req_type, symbol, position, output ready);
endinterface

interface ssms_disp_if import ssms_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SEG_W-1:0] seg_lines;
	logic [DIG_W-1:0] digit_enable;
	logic             scan_strobe;

	modport source (output valid, seg_lines, digit_enable, scan_strobe, input ready);
	modport sink (input valid, seg_lines, digit_enable, scan_strobe, output ready);
endinterface
`default_nettype wire

@@ rtl/ssms_seg_decode.sv @@
// Character to seven-segment pattern decoder.
`timescale 1ns / 1ps
`default_nettype none
module ssms_seg_decode import ssms_pkg::*; (
	input  wire logic [SYM_W-1:0] ch,
	output logic      [SEG_W-1:0] seg
);

	localparam logic [SEG_W-1:0] NUM_SEGS [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	// K, M, Q and U..Y are blank.
	localparam logic [SEG_W-1:0] LETTER_SEGS [26] = '{
		8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h7D, 8'h76, 8'h30, 8'h1E, 8'h00,
		8'h38, 8'h00, 8'h54, 8'h3F, 8'h73, 8'h00, 8'h50, 8'h6D, 8'h78, 8'h00, 8'h00,
		8'h00, 8'h00, 8'h00, 8'h5B
	};

	logic [SYM_W-1:0] upper;
	logic [SYM_W-1:0] num_off;
	logic [SYM_W-1:0] let_off;

	// Fold lower case onto upper case by dropping bit 5.
	assign upper   = ch & 8'hDF;
	assign num_off = ch - 8'h30;
	assign let_off = upper - 8'h41;

	always_comb begin
		seg = SEG_BLANK;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			seg = NUM_SEGS[num_off[3:0]];
		end else if (upper >= 8'h41 && upper <= 8'h5A) begin
			seg = LETTER_SEGS[let_off[4:0]];
		end else if (ch == CH_MINUS) begin
			seg = SEG_MINUS;
		end else if (ch == CH_UNDERSCORE) begin
			seg = SEG_UNDERSCORE;
		end
	end

endmodule
`default_nettype wire

@@ rtl/seven_segment_mux_scanner.sv @@
// Top level of the multiplexed seven-segment display scanner.
//
// Usage:
//   cmd  carries one command item per handshake: a millisecond tick, a push that
//        shifts a character in at position 0, a write of one buffer position
//        (NUL stores a space), or a clear of the buffer to spaces.
//   disp returns exactly one item per command: the held segment drive, the
//        digit enable (one-hot once scanned) and a strobe for a tick that scanned.
//   The APB port holds scan_period (byte address 0, reset 5): a scan step runs
//   on the tick that brings the tick count up to the period.
//   A command goes through the command register, then the output register or,
//   while disp stalls, the skid stage. Throughput: one item per cycle while disp
//   accepts, set by the single command register feeding state update and output.
//   The output register is backed by a one-item skid stage, so a stalled
//   receiver still lets one more command in; cmd.ready drops only once the skid
//   stage and the command register are both full.
//   Reset clears the buffer to spaces, the scan index, the tick count and the
//   held segment and digit registers, and empties all stages.
`timescale 1ns / 1ps
`default_nettype none
`include "seven_segment_mux_scanner_macros.svh"
module seven_segment_mux_scanner import ssms_pkg::*; #(
	parameter int NUM_DIGITS = NUM_DIGITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	ssms_cmd_if.sink                cmd,
	ssms_disp_if.source             disp,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [APB_DW-1:0]  pwdata,
	output logic      [APB_DW-1:0]  prdata,
	output logic                    pready
);

	localparam int IDX_W = $clog2(NUM_DIGITS);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_DIGITS - 1);

	// Configuration register.
	logic [TICK_W-1:0] scan_period_q;
	logic              cfg_wr;

	// Command register.
	logic             valid_s1;
	req_type_t        req_s1;
	logic [SYM_W-1:0] sym_s1;
	logic [POS_W-1:0] pos_s1;

	// Display state.
	logic [SYM_W-1:0]  buf_q [NUM_DIGITS];
	logic [SYM_W-1:0]  buf_d [NUM_DIGITS];
	logic [IDX_W-1:0]  scan_idx_q;
	logic [TICK_W-1:0] elapsed_q;
	logic [TICK_W-1:0] elapsed_inc;
	logic [SEG_W-1:0]  seg_q;
	logic [DIG_W-1:0]  dig_q;
	logic [SEG_W-1:0]  seg_dec;
	logic [SEG_W-1:0]  seg_decoded_w;
	logic              scan_step;

	// Output register and skid stage.
	disp_item_t res;
	disp_item_t out_q;
	disp_item_t skid_q;
	logic       out_valid_q;
	logic       skid_valid_q;
	logic       s1_adv;
	logic       out_load;
	logic       in_ready;

	// APB: writes land on the access cycle, no wait states.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_SCAN_PERIOD);

	always_comb begin
		prdata = '0;
		if (paddr[PADDR_W-1:2] == REG_SCAN_PERIOD) begin
			prdata = APB_DW'(scan_period_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q <= SCAN_PERIOD_RST;
		end else if (cfg_wr) begin
			scan_period_q <= pwdata[TICK_W-1:0];
		end
	end

	// Handshake: the command register moves on whenever the skid stage is free.
	assign s1_adv    = valid_s1 && !skid_valid_q;
	assign in_ready  = !valid_s1 || s1_adv;
	assign cmd.ready = in_ready;
	assign out_load  = !out_valid_q || disp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_ready && cmd.valid) begin
			req_s1 <= req_type_t'(cmd.req_type);
			sym_s1 <= cmd.symbol;
			pos_s1 <= cmd.position;
		end
	end

	// Decode the character at the current scan position.
	ssms_seg_decode u_decode (
		.ch  (buf_q[scan_idx_q]),
		.seg (seg_decoded_w)
	);

	assign seg_dec = seg_decoded_w;

	// Tick counting saturates; a scan runs once the count reaches the period.
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + TICK_W'(1);
	assign scan_step   = s1_adv && (req_s1 == REQ_TICK) && (elapsed_inc >= scan_period_q);

	// Buffer update for push, position write and clear.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			buf_d[i] = buf_q[i];
		end
		case (req_s1)
			REQ_PUSH: begin
				for (int i = NUM_DIGITS - 1; i > 0; i--) begin
					buf_d[i] = buf_q[i-1];
				end
				buf_d[0] = sym_s1;
			end
			REQ_WRITE: begin
				// Drop writes beyond the last digit; NUL stores a space.
				if (32'(pos_s1) < NUM_DIGITS) begin
					buf_d[IDX_W'(pos_s1)] = (sym_s1 == CH_NUL) ? CH_SPACE : sym_s1;
				end
			end
			REQ_CLEAR: begin
				for (int i = 0; i < NUM_DIGITS; i++) begin
					buf_d[i] = CH_SPACE;
				end
			end
			default: begin
			end
		endcase
	end

	// Result shows the held registers after this item's update.
	always_comb begin
		res.seg    = scan_step ? seg_dec : seg_q;
		res.dig    = scan_step ? (DIG_W'(1) << scan_idx_q) : dig_q;
		res.strobe = scan_step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				buf_q[i] <= CH_SPACE;
			end
			scan_idx_q <= '0;
			elapsed_q  <= '0;
			seg_q      <= SEG_BLANK;
			dig_q      <= '0;
		end else if (s1_adv) begin
			for (int i = 0; i < NUM_DIGITS; i++) begin
				buf_q[i] <= buf_d[i];
			end
			if (req_s1 == REQ_TICK) begin
				elapsed_q <= scan_step ? '0 : elapsed_inc;
			end
			if (scan_step) begin
				seg_q      <= res.seg;
				dig_q      <= res.dig;
				scan_idx_q <= (scan_idx_q == IDX_LAST) ? '0 : scan_idx_q + IDX_W'(1);
			end
		end
	end

	// Output register with skid: drain the skid stage first, else take the new item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q  <= skid_valid_q || s1_adv;
			skid_valid_q <= 1'b0;
		end else if (s1_adv) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (s1_adv) begin
				out_q <= res;
			end
		end else if (s1_adv) begin
			skid_q <= res;
		end
	end

	assign disp.valid        = out_valid_q;
	assign disp.seg_lines    = out_q.seg;
	assign disp.digit_enable = out_q.dig;
	assign disp.scan_strobe  = out_q.strobe;

	`SSMS_ASSERT_ALWAYS(a_idx_range, scan_idx_q <= IDX_LAST, "scan index past last digit")
	`SSMS_ASSERT_ALWAYS(a_skid_order, !skid_valid_q || out_valid_q, "skid full with output empty")
	`SSMS_ASSERT(a_scan_clears, scan_step |=> (elapsed_q == '0), "tick count kept after scan")
	`SSMS_ASSERT_ALWAYS(a_dig_onehot, $onehot0(dig_q), "digit enable not one-hot")

endmodule
`default_nettype wire
